FILE: rtl/sidta_pkg.sv
`timescale 1ns / 1ps
package sidta_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 7;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  // decimal digits needed for any magnitude of w bits
  function automatic int num_digits(input int w);
    return (w * 301) / 1000 + 1;
  endfunction

endpackage

FILE: rtl/sidta_in_if.sv
`timescale 1ns / 1ps
interface sidta_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: rtl/sidta_out_if.sv
`timescale 1ns / 1ps
interface sidta_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/sidta_front.sv
`timescale 1ns / 1ps
module sidta_front import sidta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_neg,
  output logic [VALUE_WIDTH-1:0]        out_mag
);

  logic                   valid_r;
  logic                   neg_r;
  logic [VALUE_WIDTH-1:0] mag_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // sign and magnitude, most negative value stays exact as unsigned
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      neg_r <= in_value[VALUE_WIDTH-1];
      mag_r <= in_value[VALUE_WIDTH-1] ? (~$unsigned(in_value) + 1'b1)
                                       : $unsigned(in_value);
    end
  end

  assign out_valid = valid_r;
  assign out_neg   = neg_r;
  assign out_mag   = mag_r;

endmodule

FILE: rtl/sidta_queue.sv
`timescale 1ns / 1ps
module sidta_queue import sidta_pkg::*; #(
  parameter int DATA_W = VALUE_WIDTH_DEF + 1,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              push;
  logic              pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/sidta_back.sv
`timescale 1ns / 1ps
module sidta_back import sidta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic                   q_neg,
  input  logic [VALUE_WIDTH-1:0] q_mag,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_char_code,
  output logic                   out_last_char
);

  localparam int NUM_DIGITS = num_digits(VALUE_WIDTH);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_WIDTH);
  localparam int DIG_W      = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIGN, S_DIG} state_t;

  state_t                 state_r;
  logic                   neg_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [BCD_W-1:0]       bcd_r;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       bit_cnt_r;
  logic [DIG_W-1:0]       dig_cnt_r;
  logic                   started_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      char_r;
  logic                   last_r;
  logic [3:0]             top_digit;
  logic                   out_free;
  logic                   emit_char;

  // add-3 correction per digit before each shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                 : bcd_r[4*i +: 4];
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign out_free  = !out_valid_r || out_ready;
  assign q_ready   = state_r == S_IDLE;

  always_comb begin
    emit_char = 1'b0;
    if (out_free) begin
      if (state_r == S_SIGN) begin
        emit_char = 1'b1;
      end else if (state_r == S_DIG) begin
        emit_char = top_digit != 4'd0 || started_r || dig_cnt_r == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_char) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            neg_r     <= q_neg;
            mag_r     <= q_mag;
            bcd_r     <= '0;
            bit_cnt_r <= '0;
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          {bcd_r, mag_r} <= {adj, mag_r} << 1;
          bit_cnt_r      <= bit_cnt_r + 1'b1;
          dig_cnt_r      <= DIG_W'(NUM_DIGITS - 1);
          started_r      <= 1'b0;
          if (bit_cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
            state_r <= neg_r ? S_SIGN : S_DIG;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            char_r  <= CHAR_MINUS;
            last_r  <= 1'b0;
            state_r <= S_DIG;
          end
        end
        S_DIG: begin
          if (out_free) begin
            // leading zeros are skipped, the units digit always goes out
            if (emit_char) begin
              char_r    <= CHAR_ZERO + {3'b000, top_digit};
              last_r    <= dig_cnt_r == '0;
              started_r <= 1'b1;
            end
            bcd_r <= bcd_r << 4;
            if (dig_cnt_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              dig_cnt_r <= dig_cnt_r - 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// signed integer to decimal ascii text
// in_ch: one signed VALUE_WIDTH-bit integer per transfer (valid/ready)
// out_ch: one ascii character per transfer, '-' first for negative values,
//   then the digits without leading zeros; last_char marks the final one
// a front stage takes the value and forms sign and magnitude, a two-entry
// queue holds pending values, and the back converts one item at a time
// the back first runs VALUE_WIDTH shift-and-adjust steps in the bcd converter,
//   then sends a minus sign for a negative value and walks all NUM_DIGITS digit
//   positions one per cycle while the output register is free, skipping
//   leading zeros
// up to three values are taken ahead while the back is busy
// reset clears the queue, the front stage and the output register; no
//   state carries from one item to the next
// when the receiver stalls, the current character holds on out_ch and the
//   back waits; the front keeps taking input until the queue is full
module signed_int_to_decimal_ascii import sidta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sidta_in_if.sink     in_ch,
  sidta_out_if.source  out_ch
);

  logic                   fr_valid;
  logic                   fr_ready;
  logic                   fr_neg;
  logic [VALUE_WIDTH-1:0] fr_mag;
  logic                   q_valid;
  logic                   q_ready;
  logic [VALUE_WIDTH:0]   q_data;

  sidta_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_value  (in_ch.value),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_neg   (fr_neg),
    .out_mag   (fr_mag)
  );

  sidta_queue #(.DATA_W(VALUE_WIDTH + 1), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  ({fr_neg, fr_mag}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  sidta_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_neg         (q_data[VALUE_WIDTH]),
    .q_mag         (q_data[VALUE_WIDTH-1:0]),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last_char (out_ch.last_char)
  );

endmodule

FILE: dv/decimal_text_checker.sv
`timescale 1ns / 1ps
module decimal_text_checker import sidta_pkg::*; #(
  parameter int VW = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  sidta_in_if   in_mon,
  sidta_out_if  out_mon,
  output int    fail_count,
  output int    chars_pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  ascii_char_t expected_text[$];
  ascii_char_t head;
  int          mismatches = 0;

  assign fail_count = mismatches;

  initial chars_pending = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void queue_decimal_text(input logic [VW-1:0] value);
    logic          neg;
    logic [VW-1:0] mag;
    int            digits[24];
    int            nd;
    ascii_char_t   c;
    nd  = 0;
    neg = value[VW-1];
    mag = neg ? (~value + 1'b1) : value;
    if (mag == '0) begin
      c.code = CHAR_ZERO;
      c.last = 1'b1;
      expected_text.push_back(c);
      return;
    end
    while (mag != '0) begin
      digits[nd] = int'(mag % 10);
      nd++;
      mag = mag / 10;
    end
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + CHAR_W'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // output transfer is checked before the input transfer of the same edge is queued
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b",
                                    out_mon.char_code, out_mon.last_char));
        end else begin
          head = expected_text.pop_front();
          if (out_mon.char_code !== head.code) begin
            report_mismatch($sformatf("char_code got %0d want %0d",
                                      out_mon.char_code, head.code));
          end
          if (out_mon.last_char !== head.last) begin
            report_mismatch($sformatf("last_char got %0b want %0b (char %0d)",
                                      out_mon.last_char, head.last, head.code));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        queue_decimal_text(in_mon.value);
      end
    end
    chars_pending <= expected_text.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sidta_pkg::*;

  localparam int VW          = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [VW-1:0] DIRECTED_VALUES [20] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd5, -32'sd5,
    32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA
  };

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_token;
  int   hold_seen;
  int   hold_left;
  int   cycles;
  int   fail_count;
  int   chars_pending;

  sidta_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  sidta_out_if out_ch ();

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decimal_text_checker #(.VW(VW)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    cycles        = 0;
    hold_token    = 0;
    hold_seen     = 0;
    hold_left     = 0;
    recv_idle_pct = 0;
    out_ch.ready  = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [VW-1:0] pow10(input int k);
    logic [VW-1:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    int unsigned   sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(999);
      6: v = -$urandom_range(999);
      7: begin
        v = pow10($urandom_range(9)) + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = -v;
      end
      8: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000 + $urandom_range(3);
          1: v = 32'h7FFF_FFFF - $urandom_range(3);
          2: v = $urandom_range(3);
          default: v = 32'hFFFF_FFFF - $urandom_range(3);
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [VW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    send_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct <= 58;
    foreach (DIRECTED_VALUES[i]) send_value(DIRECTED_VALUES[i]);
    for (int n = 0; n < 120; n++) send_value(pick_value());
    drain_results();

    send_idle_pct = 58;
    recv_idle_pct <= 24;
    for (int n = 0; n < 120; n++) send_value(pick_value());
    drain_results();

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_token <= hold_token + 1;
    for (int n = 0; n < 120; n++) send_value(pick_value());
    drain_results();

    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
